/* rtl/lvr_pkg.sv */
// Shared types and constants of the low-variance resampler.
package lvr_pkg;

  // Default sizes of the particle store.
  localparam int unsigned DEF_MAX_PARTICLES = 1024;
  localparam int unsigned DEF_WEIGHT_BITS   = 16;

  // Field widths on the stream ports.
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned WEIGHT_IN_W = 16;
  localparam int unsigned OFF_W       = 16;
  localparam int unsigned DRAW_W      = 11;
  localparam int unsigned SEL_W       = 10;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 16;

  // The draw target numerator {draw number, offset} and the divisor
  // {draw count, 16 zero bits} both fit this width.
  localparam int unsigned A_W = OFF_W + DRAW_W;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Control sequencer of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START_RD,
    S_START_LD,
    S_CALC,
    S_WALK_CHK,
    S_WALK_ADD,
    S_RESULT
  } state_t;

  // Sequencer of the target unit.
  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV
  } sc_state_t;

endpackage

/* rtl/lvr_ram.sv */
// Generic simple dual-port RAM with a registered read.
module lvr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lvr_scale.sv */
// Target unit: u = floor(a * t / d) by shift-add multiply, then restoring divide.
module lvr_scale
  import lvr_pkg::*;
#(
  parameter int unsigned TOT_W = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [A_W-1:0]   a,
  input  logic [A_W-1:0]   d,
  input  logic [TOT_W-1:0] t,
  output logic             done,
  output logic [TOT_W-1:0] u
);

  localparam int unsigned PROD_W = A_W + TOT_W;
  localparam int unsigned CNT_W  = $clog2(PROD_W);

  sc_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [A_W-1:0]     a_r, a_nxt;
  logic [A_W-1:0]     d_r, d_nxt;
  logic [TOT_W-1:0]   t_r, t_nxt;
  logic [PROD_W-1:0]  p_r, p_nxt;

  logic [A_W:0]       rem_trial;
  logic [A_W:0]       rem_sub;
  logic               q_bit;

  // One restoring division step: the partial remainder sits in the upper
  // part of p_r, quotient bits enter at the bottom.
  always_comb begin
    rem_trial = {p_r[PROD_W-1:TOT_W], p_r[TOT_W-1]};
    q_bit     = (rem_trial >= {1'b0, d_r});
    rem_sub   = q_bit ? (rem_trial - {1'b0, d_r}) : rem_trial;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    a_nxt     = a_r;
    d_nxt     = d_r;
    t_nxt     = t_r;
    p_nxt     = p_r;
    case (state_r)
      SC_IDLE: begin
        if (start) begin
          a_nxt     = a;
          d_nxt     = d;
          t_nxt     = t;
          p_nxt     = '0;
          cnt_nxt   = CNT_W'(A_W - 1);
          state_nxt = SC_MUL;
        end
      end
      SC_MUL: begin
        p_nxt = {p_r[PROD_W-2:0], 1'b0} + (a_r[A_W-1] ? PROD_W'(t_r) : '0);
        a_nxt = {a_r[A_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(TOT_W - 1);
          state_nxt = SC_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      SC_DIV: begin
        p_nxt = {rem_sub[A_W-1:0], p_r[TOT_W-2:0], q_bit};
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = SC_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    d_r   <= d_nxt;
    t_r   <= t_nxt;
    p_r   <= p_nxt;
  end

  assign done = done_r;
  assign u    = p_r[TOT_W-1:0];

endmodule

/* rtl/low_variance_resampler.sv */
// Low-variance (systematic) particle resampler with its weight store in RAM.
// Sequence: a load is handled in S_IDLE; a start reads the first weight in S_START_RD and
// S_START_LD. A draw waits in S_CALC for the bit-serial multiply and divide, then steps
// through S_WALK_CHK and S_WALK_ADD per weight walked; S_RESULT registers its result.
// Throughput: one request at a time; the next is taken once the result sits in the output
// register. Reset: sync, active low; clears FSM, counts, totals, draw state and out valid.
module low_variance_resampler
  import lvr_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = DEF_MAX_PARTICLES,
  parameter int unsigned WEIGHT_BITS   = DEF_WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] weight, [31:16] offset_frac, [42:32] draw_count, [47:43] zero.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] kind.
  input  logic [KIND_W-1:0]      in_tuser,
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [9:0] selected_index, [15:10] zero.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] status.
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int unsigned IDX_W = $clog2(MAX_PARTICLES);
  localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);
  // The total of all weights stays below 2^TOT_W.
  localparam int unsigned TOT_W = WEIGHT_BITS + IDX_W;

  // Request fields.
  logic [KIND_W-1:0]      in_kind;
  logic [WEIGHT_IN_W-1:0] in_weight;
  logic [OFF_W-1:0]       in_offset_frac;
  logic [DRAW_W-1:0]      in_draw_count;
  logic                   in_fire;

  assign in_kind        = in_tuser;
  assign in_weight      = in_tdata[15:0];
  assign in_offset_frac = in_tdata[31:16];
  assign in_draw_count  = in_tdata[42:32];
  assign in_fire        = in_tvalid && in_tready;

  // Control and draw state.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [DRAW_W-1:0]  dnum_r, dnum_nxt;
  logic [DRAW_W-1:0]  dreq_r, dreq_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [TOT_W-1:0]   sum_r, sum_nxt;
  logic [OFF_W-1:0]   offset_r, offset_nxt;
  logic [TOT_W-1:0]   u_r, u_nxt;
  logic               res_status_r, res_status_nxt;
  logic               res_last_r, res_last_nxt;
  logic [SEL_W-1:0]   res_sel_r, res_sel_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [SEL_W-1:0]   out_sel_r, out_sel_nxt;
  logic               out_status_r, out_status_nxt;
  logic               out_last_r, out_last_nxt;

  // Weight store port signals.
  logic [WEIGHT_BITS-1:0] wr_weight;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_rdata;

  // Target unit signals.
  logic                   sc_start;
  logic                   sc_done;
  logic [TOT_W-1:0]       sc_u;

  logic                   walk_more;
  logic                   store_full;
  logic                   draw_fail;

  assign in_tready  = (state_r == S_IDLE);
  assign wr_weight  = WEIGHT_BITS'(in_weight);
  assign store_full = (count_r == CNT_W'(MAX_PARTICLES));
  assign draw_fail  = (count_r == '0) || (dnum_r >= dreq_r);
  assign ram_we     = in_fire && (in_kind == KIND_LOAD) && !store_full;

  // The walk reads the entry after the pointer; a start reads entry zero.
  assign ram_raddr  = (state_r == S_WALK_CHK) ? IDX_W'(ptr_r + 1'b1) : '0;

  // The pointer advances while the target lies beyond the running sum,
  // stays below the total, and another loaded weight remains.
  assign walk_more = (u_r > sum_r) && (u_r < total_r) &&
                     ((CNT_W'(ptr_r) + 1'b1) < count_r);

  lvr_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_PARTICLES)
  ) u_weight_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_weight),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The target numerator is offset + draw * 65536, the divisor count * 65536.
  lvr_scale #(
    .TOT_W (TOT_W)
  ) u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .a     ({dnum_r, offset_r}),
    .d     ({dreq_r, OFF_W'(0)}),
    .t     (total_r),
    .done  (sc_done),
    .u     (sc_u)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    dnum_nxt       = dnum_r;
    dreq_nxt       = dreq_r;
    ptr_nxt        = ptr_r;
    sum_nxt        = sum_r;
    offset_nxt     = offset_r;
    u_nxt          = u_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    res_sel_nxt    = res_sel_r;
    out_valid_nxt  = out_valid_r;
    out_sel_nxt    = out_sel_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    sc_start       = 1'b0;

    // The consumer drains the output register independently of the sequencer.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            KIND_LOAD: begin
              if (!store_full) begin
                count_nxt = count_r + 1'b1;
                total_nxt = total_r + TOT_W'(wr_weight);
              end
            end
            KIND_START: begin
              offset_nxt = in_offset_frac;
              dreq_nxt   = in_draw_count;
              dnum_nxt   = '0;
              ptr_nxt    = '0;
              state_nxt  = S_START_RD;
            end
            KIND_DRAW: begin
              if (draw_fail) begin
                res_status_nxt = STATUS_EMPTY;
                res_last_nxt   = 1'b0;
                res_sel_nxt    = '0;
                state_nxt      = S_RESULT;
              end else begin
                sc_start  = 1'b1;
                state_nxt = S_CALC;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_START_RD: begin
        state_nxt = S_START_LD;
      end
      S_START_LD: begin
        sum_nxt   = (count_r != '0) ? TOT_W'(ram_rdata) : '0;
        state_nxt = S_IDLE;
      end
      S_CALC: begin
        if (sc_done) begin
          u_nxt     = sc_u;
          state_nxt = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (walk_more) begin
          state_nxt = S_WALK_ADD;
        end else begin
          res_status_nxt = STATUS_OK;
          res_last_nxt   = (DRAW_W'(dnum_r + 1'b1) == dreq_r);
          res_sel_nxt    = SEL_W'(ptr_r);
          dnum_nxt       = dnum_r + 1'b1;
          state_nxt      = S_RESULT;
        end
      end
      S_WALK_ADD: begin
        ptr_nxt   = ptr_r + 1'b1;
        sum_nxt   = sum_r + TOT_W'(ram_rdata);
        state_nxt = S_WALK_CHK;
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_sel_nxt    = res_sel_r;
          out_status_nxt = res_status_r;
          out_last_nxt   = res_last_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      dnum_r      <= '0;
      dreq_r      <= '0;
      ptr_r       <= '0;
      sum_r       <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      dnum_r      <= dnum_nxt;
      dreq_r      <= dreq_nxt;
      ptr_r       <= ptr_nxt;
      sum_r       <= sum_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r          <= u_nxt;
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
    res_sel_r    <= res_sel_nxt;
    out_sel_r    <= out_sel_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_sel_r);
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
